[rtl/atan2_pkg.sv]
// Package for the atan2 pipeline: widths, fixed-point constants, cell types.
// Used by every module under rtl/; depends on nothing.
package atan2_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned MagWidth   = CoordWidth;      // |coord| fits unsigned
  localparam int unsigned FracBits   = 20;
  localparam int unsigned RatioWidth = FracBits + 1;    // Q1.20, 0..2^20
  localparam int unsigned RemWidth   = MagWidth + 1;
  localparam int unsigned AccWidth   = 24;              // signed Horner accumulator
  localparam int unsigned AngWidth   = 16;
  localparam int unsigned OutShift   = 7;
  localparam int unsigned NumCoef    = 7;

  localparam logic [RatioWidth+1:0] PiFx     = 23'd3294199;
  localparam logic [RatioWidth+1:0] HalfPiFx = 23'd1647099;

  function automatic logic signed [AccWidth-1:0] coef(input int unsigned k);
    logic signed [AccWidth-1:0] c;
    case (k)
      0:       c = 24'sd7563;
      1:       c = -24'sd36763;
      2:       c = 24'sd85643;
      3:       c = -24'sd140243;
      4:       c = 24'sd208211;
      5:       c = -24'sd349438;
      default: c = 24'sd1048576;
    endcase
    return c;
  endfunction

  // Divider cell word: remainder, quotient bits so far, side info.
  typedef struct packed {
    logic                  vld;
    logic [RemWidth-1:0]   rem;
    logic [MagWidth-1:0]   big;
    logic [RatioWidth:0]   quo;   // one extra bit feeds final rounding
    logic                  y_big;
    logic                  x_neg;
    logic                  y_neg;
    logic                  zero;
  } div_word_t;

  // Polynomial cell word.
  typedef struct packed {
    logic                       vld;
    logic [RatioWidth-1:0]      r;
    logic [RatioWidth-1:0]      s;
    logic signed [AccWidth-1:0] acc;
    logic                       y_big;
    logic                       x_neg;
    logic                       y_neg;
    logic                       zero;
  } poly_word_t;

  // Divide by 2^20, round to nearest, ties toward +inf (floor(p/2^20 + 1/2)).
  function automatic logic signed [AccWidth-1:0] rnd_frac(input logic signed [47:0] p);
    logic signed [47:0] q;
    q = p + 48'sd524288;
    return q[FracBits+AccWidth-1:FracBits];
  endfunction

endpackage

[rtl/atan2_polynomial_approx.sv]
// atan2(y, x) in Q2.13 radians via a division cell chain and a Horner cell chain.
// The pipeline has 37 register stages (21 divider cells, ratio round, square, 6 Horner
// cells of 2 stages, final multiply, output register). Throughput: one word per cycle;
// the whole chain advances when the output register is empty or being taken. Reset
// clears only valid flags. Depends on atan2_pkg, atan2_div_cell, atan2_poly_cell.
module atan2_polynomial_approx (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [atan2_pkg::CoordWidth-1:0] x_coord_i,
  input  logic signed [atan2_pkg::CoordWidth-1:0] y_coord_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [atan2_pkg::AngWidth-1:0] angle_o
);
  localparam int unsigned NDiv      = atan2_pkg::RatioWidth;
  localparam int unsigned W         = atan2_pkg::CoordWidth;
  localparam int unsigned AngWidthL = atan2_pkg::AngWidth;

  // Single stall enable for the whole chain: advance when output slot frees.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 0: magnitudes, sort.
  logic [W:0] ax, ay;
  atan2_pkg::div_word_t s0;
  always_comb begin
    ax = x_coord_i[W-1] ? -{x_coord_i[W-1], x_coord_i} : {1'b0, x_coord_i};
    ay = y_coord_i[W-1] ? -{y_coord_i[W-1], y_coord_i} : {1'b0, y_coord_i};
    s0       = '0;
    s0.vld   = in_valid_i;
    s0.y_big = ay > ax;
    s0.x_neg = x_coord_i[W-1];
    s0.y_neg = y_coord_i[W-1];
  end
  // Magnitudes reach 2^15 which fits in MagWidth=16 bits.
  logic [W-1:0] big0, small0;
  assign big0   = s0.y_big ? ay[W-1:0] : ax[W-1:0];
  assign small0 = s0.y_big ? ax[W-1:0] : ay[W-1:0];

  atan2_pkg::div_word_t dchain [NDiv+1];
  always_comb begin
    dchain[0]      = s0;
    dchain[0].big  = big0;
    dchain[0].rem  = {1'b0, small0};
    dchain[0].quo  = '0;
    dchain[0].zero = (big0 == '0);
  end

  // Divider: 21 cells give q = floor(small*2^21/big). Equal magnitudes give
  // all ones, which still rounds to exactly 2^20 below.
  // Rounding: r = floor((q + 1)/2) equals round(small*2^20/big).
  for (genvar i = 0; i < NDiv; i++) begin : g_div
    atan2_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .d_i(dchain[i]), .d_o(dchain[i+1]));
  end

  // Ratio round and square (2 stages).
  atan2_pkg::div_word_t dq;
  logic [atan2_pkg::RatioWidth:0] rsum;
  assign dq   = dchain[NDiv];
  assign rsum = dq.quo + 1'b1;

  atan2_pkg::poly_word_t p1_q, p2_q;
  logic [1:0] pv_q;
  logic [41:0] sq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= '0;
    else if (en) pv_q <= {pv_q[0], dq.vld};
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.r     <= dq.zero ? '0 : rsum[atan2_pkg::RatioWidth:1];
      p1_q.s     <= '0;
      p1_q.acc   <= atan2_pkg::coef(0);
      p1_q.y_big <= dq.y_big;
      p1_q.x_neg <= dq.x_neg;
      p1_q.y_neg <= dq.y_neg;
      p1_q.zero  <= dq.zero;
      p1_q.vld   <= 1'b0;
      sq_q       <= p1_q.r * p1_q.r;
      p2_q       <= p1_q;
    end
  end
  logic [41:0] sqr;
  assign sqr = sq_q + 42'd524288;

  atan2_pkg::poly_word_t pchain [atan2_pkg::NumCoef];
  always_comb begin
    pchain[0]     = p2_q;
    pchain[0].s   = sqr[40:20];
    pchain[0].vld = pv_q[1];
  end

  for (genvar k = 1; k < atan2_pkg::NumCoef; k++) begin : g_poly
    atan2_poly_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .coef_i(atan2_pkg::coef(k)),
      .d_i(pchain[k-1]), .d_o(pchain[k]));
  end

  // Final multiply t = round(acc*r), then reflections and output round.
  atan2_pkg::poly_word_t pe, f_q;
  assign pe = pchain[atan2_pkg::NumCoef-1];
  logic               fv_q;
  logic signed [47:0] fp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else if (en) fv_q <= pe.vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q  <= pe;
      fp_q <= 48'(pe.acc) * $signed({27'b0, pe.r});
    end
  end

  logic signed [atan2_pkg::AccWidth-1:0] t0;
  logic signed [atan2_pkg::AccWidth:0]   t, m1, m2;
  logic [atan2_pkg::AccWidth:0]          mr;
  logic [AngWidthL-1:0]                  res;
  always_comb begin
    t0 = atan2_pkg::rnd_frac(fp_q);
    t  = {t0[atan2_pkg::AccWidth-1], t0};
    m1 = f_q.y_big ? $signed({2'b0, atan2_pkg::HalfPiFx}) - t : t;
    m2 = f_q.x_neg ? $signed({2'b0, atan2_pkg::PiFx}) - m1 : m1;
    if (m2 < 0) m2 = '0;
    mr  = m2 + 25'd64;
    res = mr[atan2_pkg::OutShift +: AngWidthL];
    if (f_q.y_neg) res = -res;
    if (f_q.zero)  res = '0;
  end

  logic ov_q;
  logic [AngWidthL-1:0] ang_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= fv_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) ang_q <= res;
  end
  assign out_valid_o = ov_q;
  assign angle_o     = ang_q;
endmodule

[rtl/atan2_div_cell.sv]
// One restoring-division step cell: one quotient bit per cycle while en_i is high.
// Depends on atan2_pkg.
module atan2_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  atan2_pkg::div_word_t  d_i,
  output atan2_pkg::div_word_t  d_o
);
  logic                               vld_q;
  atan2_pkg::div_word_t               w_q, w_d;
  logic [atan2_pkg::RemWidth:0]       sh;
  logic [atan2_pkg::RemWidth:0]       diff;

  always_comb begin
    w_d  = d_i;
    sh   = {d_i.rem, 1'b0};
    diff = sh - {2'b0, d_i.big};
    if (!diff[atan2_pkg::RemWidth]) begin
      w_d.rem = diff[atan2_pkg::RemWidth-1:0];
      w_d.quo = {d_i.quo[atan2_pkg::RatioWidth-1:0], 1'b1};
    end else begin
      w_d.rem = sh[atan2_pkg::RemWidth-1:0];
      w_d.quo = {d_i.quo[atan2_pkg::RatioWidth-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= d_i.vld;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) w_q <= w_d;
  end

  always_comb begin
    d_o     = w_q;
    d_o.vld = vld_q;
  end
endmodule

[rtl/atan2_poly_cell.sv]
// One Horner cell: acc = round(acc*s) + c, two register stages.
// Depends on atan2_pkg.
module atan2_poly_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic signed [atan2_pkg::AccWidth-1:0] coef_i,
  input  atan2_pkg::poly_word_t  d_i,
  output atan2_pkg::poly_word_t  d_o
);
  logic [1:0]            vld_q;
  atan2_pkg::poly_word_t m_q, o_q, o_d;
  logic signed [47:0]    prod_q;

  always_comb begin
    o_d     = m_q;
    o_d.acc = atan2_pkg::rnd_frac(prod_q) + coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[0], d_i.vld};
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= d_i;
      prod_q <= 48'(d_i.acc) * $signed({27'b0, d_i.s});
      o_q    <= o_d;
    end
  end
  always_comb begin
    d_o     = o_q;
    d_o.vld = vld_q[1];
  end
endmodule
